@@ src/pcw_pkg.sv @@
package pcw_pkg;

   // field and datapath widths
   localparam int DATA_W     = 32;
   localparam int LIMIT_W    = 31;
   localparam int MS_W       = 16;
   localparam int MASK_W     = 8;
   localparam int MUL_W      = 33;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int NUM_W      = PROD_W;
   localparam int DIV_W      = 33;
   localparam int MUL_CNT_W  = $clog2(MUL_W + 1);
   localparam int DIV_CNT_W  = $clog2(NUM_W + 1);
   localparam int REG_COUNT  = 8;
   localparam int CSR_ADDR_W = $clog2(REG_COUNT) + 2;

   // controller constants
   localparam logic [31:0] RATE_COEF_A = 32'd65536;
   localparam logic [31:0] RATE_COEF_B = 32'd65536;
   localparam logic [31:0] DERIV_RC    = 32'd655;
   localparam logic [31:0] OUTPUT_RC   = 32'd655;
   localparam logic [31:0] DT_MIN      = 32'd66;
   localparam logic [31:0] DT_MAX      = 32'd6554;
   localparam logic [32:0] RATE_SUM    = {1'b0, RATE_COEF_A} + {1'b0, RATE_COEF_B};
   localparam logic [DIV_W-1:0] MS_PER_S = DIV_W'(1000);

   // improve_mask bits
   localparam int IMP_TRAP     = 0;
   localparam int IMP_VRATE    = 1;
   localparam int IMP_SEPARATE = 2;
   localparam int IMP_DMEAS    = 3;
   localparam int IMP_DFILT    = 4;
   localparam int IMP_ILIMIT   = 5;
   localparam int IMP_OFILT    = 6;
   localparam int IMP_DTCLAMP  = 7;

   // opcodes
   localparam logic OP_STEP  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef enum logic [2:0] {
      REG_GAIN_P         = 3'd0,
      REG_GAIN_I         = 3'd1,
      REG_GAIN_D         = 3'd2,
      REG_MAX_OUT        = 3'd3,
      REG_INTEGRAL_LIMIT = 3'd4,
      REG_DEAD_BAND      = 3'd5,
      REG_SEPARATE_THR   = 3'd6,
      REG_IMPROVE_MASK   = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] gain_p;
      logic signed [DATA_W-1:0] gain_i;
      logic signed [DATA_W-1:0] gain_d;
      logic [LIMIT_W-1:0]       max_out;
      logic [LIMIT_W-1:0]       integral_limit;
      logic [LIMIT_W-1:0]       dead_band;
      logic [LIMIT_W-1:0]       separate_threshold;
      logic [MASK_W-1:0]        improve_mask;
   } cfg_type;

   // saturate a 34 bit signed value to 32 bits
   function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
      if ((&v[33:31]) || !(|v[33:31])) return v[31:0];
      return v[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
   endfunction

   // saturate a product-wide signed value to 32 bits
   function automatic logic signed [31:0] sat_wide(input logic signed [PROD_W-1:0] v);
      if ((&v[PROD_W-1:31]) || !(|v[PROD_W-1:31])) return v[31:0];
      return v[PROD_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
   endfunction

   // q16.16 product: floor shift then saturate
   function automatic logic signed [31:0] mulq(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] sh;
      sh = p >>> 16;
      return sat_wide(sh);
   endfunction

endpackage

@@ src/pcw_if.sv @@
interface pcw_req_if;
   import pcw_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     opcode;
   logic signed [DATA_W-1:0] measure;
   logic signed [DATA_W-1:0] setpoint;
   logic [MS_W-1:0]          elapsed_ms;
   modport source (output valid, opcode, measure, setpoint, elapsed_ms, input ready);
   modport sink (input valid, opcode, measure, setpoint, elapsed_ms, output ready);
endinterface

interface pcw_rsp_if;
   import pcw_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] drive;
   logic                     held;
   modport source (output valid, drive, held, input ready);
   modport sink (input valid, drive, held, output ready);
endinterface

@@ src/pcw_mul.sv @@
module pcw_mul (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [pcw_pkg::MUL_W-1:0]  op_a,
   input  logic signed [pcw_pkg::MUL_W-1:0]  op_b,
   output logic                              done,
   output logic signed [pcw_pkg::PROD_W-1:0] product
);
   import pcw_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 fin_ff, fin_in;
   logic                 done_ff, done_in;
   logic                 neg_ff, neg_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic [MUL_W-1:0]     mcand_ff, mcand_in;
   logic [MUL_W-1:0]     hi_ff, hi_in;
   logic [MUL_W-1:0]     lo_ff, lo_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [MUL_W:0]       sum;
   logic [PROD_W-1:0]    mag;

   // shift-add, one multiplier bit per cycle on magnitudes
   always_comb begin
      busy_in  = busy_ff;
      fin_in   = 1'b0;
      done_in  = 1'b0;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      prod_in  = prod_ff;
      sum      = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);
      mag      = {hi_ff, lo_ff};
      if (start) begin
         mcand_in = op_a[MUL_W-1] ? MUL_W'(-op_a) : op_a;
         lo_in    = op_b[MUL_W-1] ? MUL_W'(-op_b) : op_b;
         hi_in    = '0;
         neg_in   = op_a[MUL_W-1] ^ op_b[MUL_W-1];
         cnt_in   = MUL_CNT_W'(MUL_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         hi_in  = sum[MUL_W:1];
         lo_in  = {sum[0], lo_ff[MUL_W-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == MUL_CNT_W'(1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         prod_in = neg_ff ? -$signed(mag) : $signed(mag);
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      neg_ff   <= neg_in;
      cnt_ff   <= cnt_in;
      mcand_ff <= mcand_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      prod_ff  <= prod_in;
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

@@ src/pcw_div.sv @@
module pcw_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [pcw_pkg::NUM_W-1:0] numer,
   input  logic [pcw_pkg::DIV_W-1:0]        denom,
   output logic                             done,
   output logic signed [31:0]               quot
);
   import pcw_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 fin_ff, fin_in;
   logic                 done_ff, done_in;
   logic                 neg_ff, neg_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     den_ff, den_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [NUM_W-1:0]     num_ff, num_in;
   logic signed [31:0]   quot_ff, quot_in;
   logic [DIV_W+1:0]     trial;
   logic                 over;

   // restoring division, one quotient bit per cycle, truncates toward zero
   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      quot_in = quot_ff;
      trial   = {1'b0, rem_ff, num_ff[NUM_W-1]} - {2'b00, den_ff};
      over    = 1'b0;
      if (start) begin
         num_in  = numer[NUM_W-1] ? NUM_W'(-numer) : numer;
         neg_in  = numer[NUM_W-1];
         den_in  = denom;
         rem_in  = '0;
         cnt_in  = DIV_CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DIV_W+1]) begin
            rem_in = trial[DIV_W-1:0];
            num_in = {num_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DIV_W-2:0], num_ff[NUM_W-1]};
            num_in = {num_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         // saturate the signed quotient to 32 bits
         if (neg_ff) begin
            over    = (|num_ff[NUM_W-1:32]) || (num_ff[31] && (|num_ff[30:0]));
            quot_in = over ? 32'sh8000_0000 : -$signed(num_ff[31:0]);
         end else begin
            over    = |num_ff[NUM_W-1:31];
            quot_in = over ? 32'sh7FFF_FFFF : $signed(num_ff[31:0]);
         end
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

@@ src/pcw_csr.sv @@
module pcw_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [pcw_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready,
   output pcw_pkg::cfg_type                 cfg
);
   import pcw_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type idx;
   logic          wr;

   assign idx    = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_GAIN_P:         cfg_in.gain_p = pwdata;
            REG_GAIN_I:         cfg_in.gain_i = pwdata;
            REG_GAIN_D:         cfg_in.gain_d = pwdata;
            REG_MAX_OUT:        cfg_in.max_out = pwdata[LIMIT_W-1:0];
            REG_INTEGRAL_LIMIT: cfg_in.integral_limit = pwdata[LIMIT_W-1:0];
            REG_DEAD_BAND:      cfg_in.dead_band = pwdata[LIMIT_W-1:0];
            REG_SEPARATE_THR:   cfg_in.separate_threshold = pwdata[LIMIT_W-1:0];
            REG_IMPROVE_MASK:   cfg_in.improve_mask = pwdata[MASK_W-1:0];
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (idx)
         REG_GAIN_P:         prdata = cfg_ff.gain_p;
         REG_GAIN_I:         prdata = cfg_ff.gain_i;
         REG_GAIN_D:         prdata = cfg_ff.gain_d;
         REG_MAX_OUT:        prdata = {1'b0, cfg_ff.max_out};
         REG_INTEGRAL_LIMIT: prdata = {1'b0, cfg_ff.integral_limit};
         REG_DEAD_BAND:      prdata = {1'b0, cfg_ff.dead_band};
         REG_SEPARATE_THR:   prdata = {1'b0, cfg_ff.separate_threshold};
         REG_IMPROVE_MASK:   prdata = {24'd0, cfg_ff.improve_mask};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ src/pid_controller_with_improvements_core.sv @@
// channel  | dir | word contents                                   | handshake
// req_ch   | in  | opcode, measure, setpoint, elapsed_ms           | valid/ready
// rsp_ch   | out | drive, held                                     | valid/ready
// apb      | in  | psel, penable, pwrite, paddr, pwdata -> prdata  | pready tied high
//
// one word at a time; a shared serial multiplier and a shared serial divider
// set the pace.
// synchronous active-high reset clears the controller state and the registers.
// a finished word waits in the output register while the next one is taken in;
// the final step stalls only if that register is still full.
module pid_controller_with_improvements_core (
   input  logic                           clock,
   input  logic                           reset,
   pcw_req_if.sink                        req_ch,
   pcw_rsp_if.source                      rsp_ch,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [pcw_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);
   import pcw_pkg::*;

   typedef enum logic [16:0] {
      ST_IDLE  = 17'b1 << 0,
      ST_DT    = 17'b1 << 1,
      ST_CHECK = 17'b1 << 2,
      ST_P     = 17'b1 << 3,
      ST_I1    = 17'b1 << 4,
      ST_I2    = 17'b1 << 5,
      ST_D1    = 17'b1 << 6,
      ST_D2    = 17'b1 << 7,
      ST_VR    = 17'b1 << 8,
      ST_V1    = 17'b1 << 9,
      ST_V2    = 17'b1 << 10,
      ST_SEP   = 17'b1 << 11,
      ST_F1    = 17'b1 << 12,
      ST_F2    = 17'b1 << 13,
      ST_F3    = 17'b1 << 14,
      ST_LIM   = 17'b1 << 15,
      ST_SUM   = 17'b1 << 16
   } state_type;

   cfg_type cfg;

   state_type state_ff, state_in;
   logic      fin_ff, fin_in;
   logic      launched_ff, launched_in;
   logic      held_ff, held_in;
   logic      clr_ff, clr_in;
   logic      filt_out_ff, filt_out_in;
   logic      sum_drive_ff, sum_drive_in;
   logic [MS_W-1:0]   ms_ff, ms_in;
   logic [31:0]       dt_ff, dt_in;
   logic signed [31:0] meas_ff, meas_in;
   logic signed [31:0] err_ff, err_in;
   logic signed [31:0] pterm_ff, pterm_in;
   logic signed [31:0] iterm_ff, iterm_in;
   logic signed [31:0] dterm_ff, dterm_in;
   logic signed [31:0] iout_ff, iout_in;
   logic signed [31:0] drive_ff, drive_in;
   logic signed [31:0] tmp_ff, tmp_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [31:0] prev_measure_ff, prev_measure_in;
   logic signed [31:0] prev_error_ff, prev_error_in;
   logic signed [31:0] prev_drive_ff, prev_drive_in;
   logic signed [31:0] prev_deriv_ff, prev_deriv_in;
   logic signed [31:0] integral_sum_ff, integral_sum_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_drive_ff, rsp_drive_in;
   logic               rsp_held_ff, rsp_held_in;

   logic                     mul_start, mul_done;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_product;
   logic                     div_start, div_done;
   logic signed [NUM_W-1:0]  div_numer;
   logic [DIV_W-1:0]         div_denom;
   logic signed [31:0]       div_quot;

   logic               accept;
   logic               out_free;
   logic signed [32:0] err_raw;
   logic [31:0]        aerr;
   logic signed [32:0] err_sum;
   logic signed [32:0] diff_raw;
   logic signed [31:0] diff_sat;
   logic signed [31:0] filt_cur;
   logic signed [31:0] filt_prev;
   logic [31:0]        filt_rc;
   logic [DIV_W-1:0]   filt_den;
   logic [32:0]        rate_fac;
   logic [31:0]        dt_clip;
   logic               same_sign;
   logic signed [33:0] tmp_i;
   logic signed [33:0] tmp_o;
   logic signed [33:0] abs_o;
   logic signed [33:0] lim_pos;
   logic signed [31:0] max_s;

   pcw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pcw_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_product)
   );

   pcw_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (div_denom),
      .done  (div_done),
      .quot  (div_quot)
   );

   // handshake
   assign req_ch.ready  = (state_ff == ST_IDLE) && !fin_ff;
   assign accept        = req_ch.valid && req_ch.ready;
   assign out_free      = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.drive  = rsp_drive_ff;
   assign rsp_ch.held   = rsp_held_ff;

   // shared datapath terms
   always_comb begin
      err_raw   = 33'(req_ch.setpoint) - 33'(req_ch.measure);
      aerr      = err_ff[31] ? 32'(-err_ff) : err_ff;
      err_sum   = 33'(err_ff) + 33'(prev_error_ff);
      diff_raw  = cfg.improve_mask[IMP_DMEAS] ? 33'(prev_measure_ff) - 33'(meas_ff)
                                              : 33'(err_ff) - 33'(prev_error_ff);
      diff_sat  = sat34(34'(diff_raw));
      filt_cur  = filt_out_ff ? drive_ff : dterm_ff;
      filt_prev = filt_out_ff ? prev_drive_ff : prev_deriv_ff;
      filt_rc   = filt_out_ff ? OUTPUT_RC : DERIV_RC;
      filt_den  = {1'b0, filt_rc} + {1'b0, dt_ff};
      rate_fac  = RATE_SUM - {1'b0, aerr};
      same_sign = (err_ff[31] == iout_ff[31]);
      tmp_i     = 34'(iout_ff) + 34'(iterm_ff);
      tmp_o     = 34'(pterm_ff) + 34'(iout_ff) + 34'(dterm_ff);
      abs_o     = tmp_o[33] ? -tmp_o : tmp_o;
      lim_pos   = $signed({3'b000, cfg.integral_limit});
      max_s     = $signed({1'b0, cfg.max_out});
      dt_clip   = div_quot;
      if (cfg.improve_mask[IMP_DTCLAMP]) begin
         if (dt_clip > DT_MAX) dt_clip = DT_MAX;
         if (dt_clip < DT_MIN) dt_clip = DT_MIN;
      end
   end

   // operand steering for the serial units
   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      mul_start = 1'b0;
      div_numer = '0;
      div_denom = '0;
      div_start = 1'b0;
      case (state_ff)
         ST_P: begin
            mul_a = MUL_W'(cfg.gain_p);
            mul_b = MUL_W'(err_ff);
         end
         ST_I1: begin
            mul_a = MUL_W'(cfg.gain_i);
            mul_b = cfg.improve_mask[IMP_TRAP] ? MUL_W'($signed(err_sum[32:1]))
                                               : MUL_W'(err_ff);
         end
         ST_I2: begin
            mul_a = MUL_W'(tmp_ff);
            mul_b = $signed({1'b0, dt_ff});
         end
         ST_D1: begin
            mul_a = MUL_W'(cfg.gain_d);
            mul_b = MUL_W'(diff_sat);
         end
         ST_V1: begin
            mul_a = MUL_W'(iterm_ff);
            mul_b = $signed(rate_fac);
         end
         ST_F1: begin
            mul_a = MUL_W'(filt_cur);
            mul_b = $signed({1'b0, dt_ff});
         end
         ST_F2: begin
            mul_a = MUL_W'(filt_prev);
            mul_b = $signed({1'b0, filt_rc});
         end
         ST_DT: begin
            div_numer = $signed({34'd0, ms_ff, 16'd0});
            div_denom = MS_PER_S;
         end
         ST_D2: begin
            div_numer = $signed({{18{tmp_ff[31]}}, tmp_ff, 16'd0});
            div_denom = {1'b0, dt_ff};
         end
         ST_V2: begin
            div_numer = prod_ff;
            div_denom = {1'b0, RATE_COEF_A};
         end
         ST_F3: begin
            div_numer = prod_ff;
            div_denom = filt_den;
         end
         default: ;
      endcase
      case (state_ff)
         ST_P, ST_I1, ST_I2, ST_D1, ST_V1, ST_F1, ST_F2: mul_start = !launched_ff;
         ST_DT, ST_D2, ST_V2, ST_F3:                     div_start = !launched_ff;
         default: ;
      endcase
   end

   // step sequencer
   always_comb begin
      state_in        = state_ff;
      fin_in          = fin_ff;
      launched_in     = launched_ff;
      held_in         = held_ff;
      clr_in          = clr_ff;
      filt_out_in     = filt_out_ff;
      sum_drive_in    = sum_drive_ff;
      ms_in           = ms_ff;
      dt_in           = dt_ff;
      meas_in         = meas_ff;
      err_in          = err_ff;
      pterm_in        = pterm_ff;
      iterm_in        = iterm_ff;
      dterm_in        = dterm_ff;
      iout_in         = iout_ff;
      drive_in        = drive_ff;
      tmp_in          = tmp_ff;
      prod_in         = prod_ff;
      prev_measure_in = prev_measure_ff;
      prev_error_in   = prev_error_ff;
      prev_drive_in   = prev_drive_ff;
      prev_deriv_in   = prev_deriv_ff;
      integral_sum_in = integral_sum_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      rsp_drive_in    = rsp_drive_ff;
      rsp_held_in     = rsp_held_ff;

      if (mul_start || div_start) launched_in = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               meas_in = req_ch.measure;
               ms_in   = req_ch.elapsed_ms;
               err_in  = sat34(34'(err_raw));
               held_in = 1'b0;
               if (req_ch.opcode == OP_CLEAR) begin
                  prev_error_in   = '0;
                  prev_drive_in   = '0;
                  prev_deriv_in   = '0;
                  integral_sum_in = '0;
                  drive_in        = '0;
                  clr_in          = 1'b1;
                  fin_in          = 1'b1;
               end else begin
                  clr_in   = 1'b0;
                  state_in = ST_DT;
               end
            end
         end
         ST_DT: begin
            if (div_done) begin
               launched_in = 1'b0;
               dt_in       = dt_clip;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // deadband: hold last drive
            if (aerr > {1'b0, cfg.dead_band}) begin
               iout_in  = integral_sum_ff;
               state_in = ST_P;
            end else begin
               drive_in = prev_drive_ff;
               held_in  = 1'b1;
               fin_in   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_P: begin
            if (mul_done) begin
               launched_in = 1'b0;
               pterm_in    = mulq(mul_product);
               state_in    = ST_I1;
            end
         end
         ST_I1: begin
            if (mul_done) begin
               launched_in = 1'b0;
               tmp_in      = mulq(mul_product);
               state_in    = ST_I2;
            end
         end
         ST_I2: begin
            if (mul_done) begin
               launched_in = 1'b0;
               iterm_in    = mulq(mul_product);
               if (dt_ff == '0) begin
                  dterm_in = '0;
                  state_in = ST_VR;
               end else begin
                  state_in = ST_D1;
               end
            end
         end
         ST_D1: begin
            if (mul_done) begin
               launched_in = 1'b0;
               tmp_in      = mulq(mul_product);
               state_in    = ST_D2;
            end
         end
         ST_D2: begin
            if (div_done) begin
               launched_in = 1'b0;
               dterm_in    = div_quot;
               state_in    = ST_VR;
            end
         end
         ST_VR: begin
            // variable-rate integration
            state_in = ST_SEP;
            if (cfg.improve_mask[IMP_VRATE] && same_sign && (aerr > RATE_COEF_B)) begin
               if (({1'b0, aerr} <= RATE_SUM) && (RATE_COEF_A != '0)) begin
                  state_in = ST_V1;
               end else begin
                  iterm_in = '0;
               end
            end
         end
         ST_V1: begin
            if (mul_done) begin
               launched_in = 1'b0;
               prod_in     = mul_product;
               state_in    = ST_V2;
            end
         end
         ST_V2: begin
            if (div_done) begin
               launched_in = 1'b0;
               iterm_in    = div_quot;
               state_in    = ST_SEP;
            end
         end
         ST_SEP: begin
            // integral separation
            if (cfg.improve_mask[IMP_SEPARATE] && (cfg.separate_threshold != '0)
                && (aerr > {1'b0, cfg.separate_threshold})) begin
               iout_in  = '0;
               iterm_in = '0;
            end
            filt_out_in = 1'b0;
            state_in    = cfg.improve_mask[IMP_DFILT] ? ST_F1 : ST_LIM;
         end
         ST_F1: begin
            if (mul_done) begin
               launched_in = 1'b0;
               prod_in     = mul_product;
               state_in    = ST_F2;
            end
         end
         ST_F2: begin
            if (mul_done) begin
               launched_in = 1'b0;
               prod_in     = prod_ff + mul_product;
               state_in    = ST_F3;
            end
         end
         ST_F3: begin
            if (div_done) begin
               launched_in = 1'b0;
               if (filt_out_ff) begin
                  drive_in = (filt_den == '0) ? filt_cur : div_quot;
                  fin_in   = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  dterm_in = (filt_den == '0) ? filt_cur : div_quot;
                  state_in = ST_LIM;
               end
            end
         end
         ST_LIM: begin
            // integral clamp with anti-windup
            if (cfg.improve_mask[IMP_ILIMIT]) begin
               if ((abs_o > $signed({3'b000, cfg.max_out}))
                   && ((!cfg.gain_i[31] && (cfg.gain_i != '0) && same_sign)
                       || (cfg.gain_i[31] && !same_sign))) begin
                  iterm_in = '0;
               end
               if (tmp_i > lim_pos) begin
                  iterm_in = '0;
                  iout_in  = $signed({1'b0, cfg.integral_limit});
               end
               if (tmp_i < -lim_pos) begin
                  iterm_in = '0;
                  iout_in  = -$signed({1'b0, cfg.integral_limit});
               end
            end
            sum_drive_in = 1'b0;
            state_in     = ST_SUM;
         end
         ST_SUM: begin
            // first pass integral, second pass drive
            if (!sum_drive_ff) begin
               iout_in      = sat34(34'(iout_ff) + 34'(iterm_ff));
               sum_drive_in = 1'b1;
            end else begin
               drive_in = sat34(tmp_o);
               if (cfg.improve_mask[IMP_OFILT]) begin
                  filt_out_in = 1'b1;
                  state_in    = ST_F1;
               end else begin
                  fin_in   = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // result hand-off and state update
      if (fin_ff && out_free) begin
         fin_in       = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_held_in  = held_ff;
         if (clr_ff) begin
            rsp_drive_in = '0;
         end else if (held_ff) begin
            rsp_drive_in    = drive_ff;
            prev_measure_in = meas_ff;
            prev_error_in   = err_ff;
         end else begin
            rsp_drive_in = drive_ff;
            if (drive_ff > max_s) rsp_drive_in = max_s;
            if (drive_ff < -max_s) rsp_drive_in = -max_s;
            prev_drive_in   = rsp_drive_in;
            prev_measure_in = meas_ff;
            prev_error_in   = err_ff;
            prev_deriv_in   = dterm_ff;
            integral_sum_in = iout_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         fin_ff          <= 1'b0;
         launched_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         prev_measure_ff <= '0;
         prev_error_ff   <= '0;
         prev_drive_ff   <= '0;
         prev_deriv_ff   <= '0;
         integral_sum_ff <= '0;
      end else begin
         state_ff        <= state_in;
         fin_ff          <= fin_in;
         launched_ff     <= launched_in;
         rsp_valid_ff    <= rsp_valid_in;
         prev_measure_ff <= prev_measure_in;
         prev_error_ff   <= prev_error_in;
         prev_drive_ff   <= prev_drive_in;
         prev_deriv_ff   <= prev_deriv_in;
         integral_sum_ff <= integral_sum_in;
      end
      held_ff      <= held_in;
      clr_ff       <= clr_in;
      filt_out_ff  <= filt_out_in;
      sum_drive_ff <= sum_drive_in;
      ms_ff        <= ms_in;
      dt_ff        <= dt_in;
      meas_ff      <= meas_in;
      err_ff       <= err_in;
      pterm_ff     <= pterm_in;
      iterm_ff     <= iterm_in;
      dterm_ff     <= dterm_in;
      iout_ff      <= iout_in;
      drive_ff     <= drive_in;
      tmp_ff       <= tmp_in;
      prod_ff      <= prod_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_held_ff  <= rsp_held_in;
   end

endmodule

@@ verif/pid_controller_with_improvements_core_tb.sv @@
module pid_controller_with_improvements_core_tb;
   import pcw_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int TAIL_CYCLES    = 1000;

   typedef struct {
      logic signed [DATA_W-1:0] drive;
      logic                     held;
   } drive_word_type;

   logic clock;
   logic reset;
   logic psel, penable, pwrite, pready;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0] pwdata, prdata;

   pcw_req_if req_ch ();
   pcw_rsp_if rsp_ch ();

   pid_controller_with_improvements_core u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch.sink),
      .rsp_ch  (rsp_ch.source),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // expected drive words, oldest first
   drive_word_type expected_drive_q[$];
   int mismatch_count = 0;
   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int rsp_hold_cycles = 0;
   int quiet_cycles   = 0;

   // controller shadow: configuration
   longint k_p, k_i, k_d, lim_out, lim_int, band, sep_thr;
   logic [MASK_W-1:0] opts;
   // controller shadow: state
   longint last_meas, prior_err, last_drive, last_deriv, int_acc;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return sat32((a * b) >>> 16);
   endfunction

   function automatic longint labs(longint x);
      return x < 0 ? -x : x;
   endfunction

   function automatic bit same_sign(longint a, longint b);
      return (a >= 0) == (b >= 0);
   endfunction

   function automatic longint rate_deriv(longint diff, longint dt);
      longint num;
      if (dt <= 0) return 0;
      num = qmul(k_d, sat32(diff));
      return sat32((num * 65536) / dt);
   endfunction

   function automatic longint smooth(longint cur, longint prev, longint rc, longint dt);
      longint den;
      den = rc + dt;
      if (den <= 0) return cur;
      return sat32((cur * dt + prev * rc) / den);
   endfunction

   // one control step of the shadow controller
   function automatic drive_word_type control_step(logic op, logic signed [31:0] m_in,
                                                   logic signed [31:0] s_in,
                                                   logic [15:0] ms);
      drive_word_type w;
      longint meas, sp, dt, err, aerr, pt, it, dtm, iout, drv, s, avg, a, b, ti, tout;
      w.held = 1'b0;
      if (op == OP_CLEAR) begin
         prior_err = 0; last_drive = 0; last_deriv = 0; int_acc = 0;
         w.drive = '0;
         return w;
      end
      meas = m_in;
      sp   = s_in;
      dt   = (longint'(ms) * 65536) / 1000;
      if (opts[IMP_DTCLAMP]) begin
         if (dt > longint'(DT_MAX)) dt = DT_MAX;
         if (dt < longint'(DT_MIN)) dt = DT_MIN;
      end
      err  = sat32(sp - meas);
      aerr = labs(err);
      if (aerr > band) begin
         iout = int_acc;
         pt   = qmul(k_p, err);
         it   = qmul(qmul(k_i, err), dt);
         dtm  = rate_deriv(err - prior_err, dt);
         // trapezoid integration
         if (opts[IMP_TRAP]) begin
            s   = err + prior_err;
            avg = s >= 0 ? s / 2 : -((-s + 1) / 2);
            it  = qmul(qmul(k_i, avg), dt);
         end
         // variable-rate integration
         if (opts[IMP_VRATE] && same_sign(err, iout)) begin
            a = RATE_COEF_A;
            b = RATE_COEF_B;
            if (aerr > b) begin
               if (aerr <= a + b && a >= 1) it = sat32(it * (a + b - aerr) / a);
               else it = 0;
            end
         end
         // integral separation
         if (opts[IMP_SEPARATE] && sep_thr > 0 && aerr > sep_thr) begin
            iout = 0;
            it   = 0;
         end
         if (opts[IMP_DMEAS]) dtm = rate_deriv(last_meas - meas, dt);
         if (opts[IMP_DFILT]) dtm = smooth(dtm, last_deriv, DERIV_RC, dt);
         // anti-windup and integral clamp
         if (opts[IMP_ILIMIT]) begin
            ti   = iout + it;
            tout = pt + iout + dtm;
            if (labs(tout) > lim_out) begin
               if ((k_i > 0 && same_sign(err, iout)) || (k_i < 0 && !same_sign(err, iout)))
                  it = 0;
            end
            if (ti > lim_int) begin
               it = 0; iout = lim_int;
            end
            if (ti < -lim_int) begin
               it = 0; iout = -lim_int;
            end
         end
         iout = sat32(iout + it);
         drv  = sat32(pt + iout + dtm);
         if (opts[IMP_OFILT]) drv = smooth(drv, last_drive, OUTPUT_RC, dt);
         if (drv > lim_out) drv = lim_out;
         if (drv < -lim_out) drv = -lim_out;
         int_acc    = iout;
         last_deriv = dtm;
      end else begin
         drv    = last_drive;
         w.held = 1'b1;
      end
      last_meas  = meas;
      last_drive = drv;
      prior_err  = err;
      w.drive    = drv[31:0];
      return w;
   endfunction

   // csr write, setup then access
   task automatic csr_write(reg_index_type idx, logic [31:0] val);
      @(negedge clock);
      psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
      paddr = CSR_ADDR_W'(idx) << 2;
      pwdata = val;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      case (idx)
         REG_GAIN_P:         k_p = longint'(signed'(val));
         REG_GAIN_I:         k_i = longint'(signed'(val));
         REG_GAIN_D:         k_d = longint'(signed'(val));
         REG_MAX_OUT:        lim_out = val[30:0];
         REG_INTEGRAL_LIMIT: lim_int = val[30:0];
         REG_DEAD_BAND:      band = val[30:0];
         REG_SEPARATE_THR:   sep_thr = val[30:0];
         REG_IMPROVE_MASK:   opts = val[7:0];
         default: ;
      endcase
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
   endtask

   task automatic load_gains(logic [31:0] gp, logic [31:0] gi, logic [31:0] gd,
                             logic [31:0] mo, logic [31:0] il, logic [31:0] db,
                             logic [31:0] st, logic [31:0] msk);
      csr_write(REG_GAIN_P, gp);
      csr_write(REG_GAIN_I, gi);
      csr_write(REG_GAIN_D, gd);
      csr_write(REG_MAX_OUT, mo);
      csr_write(REG_INTEGRAL_LIMIT, il);
      csr_write(REG_DEAD_BAND, db);
      csr_write(REG_SEPARATE_THR, st);
      csr_write(REG_IMPROVE_MASK, msk);
   endtask

   // send one word; valid stays high into the next word when no gap is taken
   task automatic send_word(logic op, logic [31:0] m, logic [31:0] s, logic [15:0] ms);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.opcode = op;
      req_ch.measure = m;
      req_ch.setpoint = s;
      req_ch.elapsed_ms = ms;
      do @(posedge clock); while (!req_ch.ready);
      expected_drive_q.push_back(control_step(op, m, s, ms));
   endtask

   task automatic idle_input();
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   task automatic wait_drained();
      idle_input();
      while (expected_drive_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_q();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'h8000_0000 | ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h0);
         2: return $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
         default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      endcase
   endfunction

   function automatic logic [15:0] pick_ms();
      case ($urandom_range(0, 7))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: return $urandom_range(0, 120);
      endcase
   endfunction

   task automatic random_config();
      load_gains($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0004_0000) - 32'h0002_0000,
                 $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0004_0000) - 32'h0002_0000,
                 $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0000_4000) - 32'h0000_2000,
                 $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0040_0000),
                 $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0020_0000),
                 $urandom_range(0, 2) == 0 ? $urandom_range(0, 32'h0000_2000) : 32'h0,
                 $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0010_0000),
                 $urandom_range(0, 255));
   endtask

   task automatic send_random(int count);
      for (int n = 0; n < count; n++)
         send_word($urandom_range(0, 19) == 0 ? OP_CLEAR : OP_STEP, pick_q(), pick_q(), pick_ms());
   endtask

   // directed: field extremes, clear, hold, zero dt, dt clamp, filters
   task automatic test_directed();
      load_gains(32'h0001_0000, 32'h0000_8000, 32'h0000_0100, 32'h0100_0000,
                 32'h0080_0000, 32'h0000_0100, 32'h0008_0000, 8'h00);
      send_word(OP_STEP, 32'h0, 32'h0, 16'd10);
      send_word(OP_STEP, 32'h0, 32'h0001_0000, 16'd10);
      send_word(OP_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0);
      send_word(OP_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
      send_word(OP_STEP, 32'h0000_0010, 32'h0000_0020, 16'd5);
      send_word(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      send_word(OP_STEP, 32'h0002_0000, 32'h0, 16'd1);
      wait_drained();
      load_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h0, 32'h0001_0000, 8'hFF);
      send_word(OP_STEP, 32'h0, 32'h0000_8000, 16'd0);
      send_word(OP_STEP, 32'h0, 32'h0001_8000, 16'hFFFF);
      send_word(OP_STEP, 32'hFFFF_0000, 32'h0001_0000, 16'd1);
      send_word(OP_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 16'd50);
      send_word(OP_STEP, 32'h1234_5678, 32'h1234_5678, 16'd50);
      send_word(OP_CLEAR, 32'h0, 32'h0, 16'd0);
      wait_drained();
      load_gains(32'h0002_0000, 32'h0004_0000, 32'h8000_0000, 32'h0, 32'h0,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'h7F);
      send_word(OP_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 16'd20);
      send_word(OP_STEP, 32'h0, 32'h0, 16'd0);
      wait_drained();
      load_gains(32'h0001_0000, 32'h0001_0000, 32'h0000_1000, 32'h0040_0000,
                 32'h0004_0000, 32'h0, 32'h0, 8'h33);
      send_word(OP_STEP, 32'h0, 32'h0003_0000, 16'd30);
      send_word(OP_STEP, 32'h0, 32'h0001_8000, 16'd30);
      send_word(OP_STEP, 32'h0, 32'hFFFE_0000, 16'd30);
      wait_drained();
   endtask

   task automatic test_no_idle();
      random_config();
      send_idle_pct = 0; rsp_stall_pct = 0;
      send_random(150);
      wait_drained();
   endtask

   task automatic test_sender_idle();
      random_config();
      send_idle_pct = 81; rsp_stall_pct = 0;
      send_random(150);
      wait_drained();
   endtask

   task automatic test_receiver_stall();
      random_config();
      send_idle_pct = 0; rsp_stall_pct = 81;
      send_random(150);
      wait_drained();
   endtask

   task automatic test_both_idle();
      load_gains(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h0, 32'h0, 32'h0, 8'hFF);
      send_idle_pct = 23; rsp_stall_pct = 23;
      send_random(100);
      wait_drained();
      random_config();
      send_random(100);
      wait_drained();
   endtask

   // long receiver hold-off while the sender keeps offering words
   task automatic test_backpressure();
      random_config();
      send_idle_pct = 0; rsp_stall_pct = 0;
      rsp_hold_cycles = 4000;
      send_random(60);
      wait_drained();
      // sender pauses until drained, then resumes
      send_random(20);
      wait_drained();
   endtask

   // receiver ready, with an optional long hold-off
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles <= rsp_hold_cycles - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // compare each drive word with the oldest expectation
   always @(posedge clock) begin
      drive_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_drive_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected drive word: drive %h held %b", rsp_ch.drive, rsp_ch.held);
         end else begin
            want = expected_drive_q.pop_front();
            if (want.drive !== rsp_ch.drive || want.held !== rsp_ch.held) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("drive word mismatch: expected drive %h held %b, got drive %h held %b",
                           want.drive, want.held, rsp_ch.drive, rsp_ch.held);
            end
         end
      end
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      req_ch.valid = 1'b0; req_ch.opcode = OP_STEP;
      req_ch.measure = '0; req_ch.setpoint = '0; req_ch.elapsed_ms = '0;
      rsp_ch.ready = 1'b0;
      k_p = 0; k_i = 0; k_d = 0; lim_out = 0; lim_int = 0; band = 0; sep_thr = 0;
      opts = '0;
      last_meas = 0; prior_err = 0; last_drive = 0; last_deriv = 0; int_acc = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_no_idle();
      test_sender_idle();
      test_receiver_stall();
      test_both_idle();
      test_backpressure();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_drive_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
